>>> design/bafl_pkg.sv
// bafl_pkg: shared constants, types and helpers for the buddy allocator
// no dependencies
package bafl_pkg;

  localparam int HeapOrder  = 16;
  localparam int MinOrder   = 2;
  localparam int BlkW       = HeapOrder - MinOrder;      // block number bits
  localparam int LinkW      = BlkW + 1;                  // valid bit over block number
  localparam int OrdW       = 5;                         // holds 0..31
  localparam int SizeW      = 17;
  localparam int OffW       = 16;
  localparam int HeadIdxW   = $clog2(HeapOrder);

  localparam logic CmdAlloc = 1'b0;
  localparam logic CmdFree  = 1'b1;

  // datapath commands
  typedef enum logic [3:0] {
    OpNone,
    OpLoad,       // capture request, compute order
    OpScanUp,     // alloc: advance p
    OpPop,        // alloc: start read of next link of head block
    OpPopDone,    // alloc: head <= link
    OpSplit,      // alloc: push right half, p--
    OpFindStart,  // free: cur <= head of p
    OpFindRd,     // free: issue link read of cur
    OpFindStep,   // free: evaluate read data
    OpUnlink,     // free: perform unlink and merge
    OpPushLast,   // free: push block
    OpReply
  } op_e;

  typedef struct packed {
    op_e op;
  } ctl_t;

  typedef struct packed {
    logic req_bad;     // size zero, too big, or misaligned free
    logic is_free;
    logic head_valid;  // head of current order valid
    logic p_top;       // p >= HeapOrder
    logic p_want;      // p == want
    logic cur_valid;
    logic cur_hit;
    logic steps_done;
  } sts_t;

  // ceil log2 of size, at least MinOrder
  function automatic logic [OrdW-1:0] order_of(input logic [SizeW-1:0] n);
    logic [SizeW-1:0] m;
    logic [OrdW-1:0]  p;
    m = n - 1'b1;
    p = '0;
    for (int i = 0; i < SizeW; i++) begin
      if (m[i]) p = OrdW'(i + 1);
    end
    return (p < OrdW'(MinOrder)) ? OrdW'(MinOrder) : p;
  endfunction

endpackage

>>> design/bafl_ctrl.sv
// bafl_ctrl: sequencer for allocate and free operations
// depends on bafl_pkg
module bafl_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bafl_pkg::sts_t sts_i,
  input  logic          out_free_i,
  output bafl_pkg::ctl_t ctl_o,
  output logic          idle_o
);
  import bafl_pkg::*;

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SLoad   = 4'd1;
  localparam logic [3:0] SScan   = 4'd2;
  localparam logic [3:0] SPop    = 4'd3;
  localparam logic [3:0] SPopW   = 4'd4;
  localparam logic [3:0] SSplit  = 4'd5;
  localparam logic [3:0] SFind   = 4'd6;
  localparam logic [3:0] SFRd    = 4'd7;
  localparam logic [3:0] SFStep  = 4'd8;
  localparam logic [3:0] SUnlink = 4'd9;
  localparam logic [3:0] SPush   = 4'd10;
  localparam logic [3:0] SReply  = 4'd11;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else         state_q <= state_d;
  end

  // next state and command
  always_comb begin
    state_d   = state_q;
    ctl_o.op  = OpNone;
    case (state_q)
      SIdle: begin
        if (start_i) begin
          ctl_o.op = OpLoad;
          state_d  = SLoad;
        end
      end
      SLoad: begin
        if (sts_i.req_bad)      state_d = SReply;
        else if (sts_i.is_free) state_d = SFind;
        else                    state_d = SScan;
      end
      SScan: begin
        if (sts_i.head_valid) state_d = SPop;
        else if (sts_i.p_top) state_d = SReply;
        else ctl_o.op = OpScanUp;
      end
      SPop: begin
        ctl_o.op = OpPop;
        state_d  = SPopW;
      end
      SPopW: begin
        ctl_o.op = OpPopDone;
        state_d  = SSplit;
      end
      SSplit: begin
        if (sts_i.p_want) state_d = SReply;
        else ctl_o.op = OpSplit;
      end
      SFind: begin
        if (sts_i.p_top) state_d = SPush;
        else begin
          ctl_o.op = OpFindStart;
          state_d  = SFRd;
        end
      end
      SFRd: begin
        if (!sts_i.cur_valid || sts_i.steps_done) state_d = SPush;
        else if (sts_i.cur_hit) begin
          ctl_o.op = OpFindRd;
          state_d  = SUnlink;
        end else begin
          ctl_o.op = OpFindRd;
          state_d  = SFStep;
        end
      end
      SFStep: begin
        ctl_o.op = OpFindStep;
        state_d  = SFRd;
      end
      SUnlink: begin
        ctl_o.op = OpUnlink;
        state_d  = SFind;
      end
      SPush: begin
        ctl_o.op = OpPushLast;
        state_d  = SReply;
      end
      SReply: begin
        if (out_free_i) begin
          ctl_o.op = OpReply;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  assign idle_o = (state_q == SIdle);
endmodule

>>> design/bafl_dp.sv
// bafl_dp: list heads, link memory and block arithmetic
// depends on bafl_pkg
module bafl_dp (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  bafl_pkg::ctl_t            ctl_i,
  input  logic                      cmd_i,
  input  logic [bafl_pkg::SizeW-1:0] req_size_i,
  input  logic [bafl_pkg::OffW-1:0] block_offset_i,
  output bafl_pkg::sts_t            sts_o,
  output logic                      res_ok_o,
  output logic [bafl_pkg::OffW-1:0] res_off_o
);
  import bafl_pkg::*;

  // list heads: reset value only top order holds block 0
  logic [LinkW-1:0] heads_q [HeapOrder];
  // next links memory, undefined until written except entry 0 (null)
  logic [LinkW-1:0] links [2**BlkW];
  logic [LinkW-1:0] rd_mem_q;
  logic             rd_zero_q;
  logic             link0_set_q;
  logic [LinkW-1:0] rd_link;

  logic             free_q, bad_q;
  logic [OrdW-1:0]  want_q, p_q;
  logic [BlkW-1:0]  blk_q, prev_q;
  logic             at_head_q;
  logic [LinkW-1:0] cur_q;
  logic [BlkW:0]    steps_q;
  logic             ok_q;

  logic [OrdW-1:0]  ld_ord;
  logic             ld_bad;
  logic [HeadIdxW-1:0] hidx;
  logic [BlkW:0]    span_w;
  logic [BlkW-1:0]  span;
  logic [BlkW-1:0]  half;
  logic [BlkW-1:0]  buddy;
  logic [OffW:0]    offmask;

  // span of the current order in blocks, and half of it for splits
  assign hidx   = HeadIdxW'(p_q - 1'b1);
  assign span_w = (BlkW+1)'(1) << (p_q - OrdW'(MinOrder));
  assign span   = span_w[BlkW-1:0];
  assign half   = span_w[BlkW:1];
  assign buddy  = blk_q ^ span;

  // request check on load
  always_comb begin
    ld_ord  = order_of(req_size_i);
    offmask = ((OffW+1)'(1) << ld_ord) - 1'b1;
    ld_bad  = (req_size_i == '0) || (ld_ord > OrdW'(HeapOrder));
    if (cmd_i == CmdFree && ((OffW+1)'(block_offset_i) & offmask) != '0) ld_bad = 1'b1;
  end

  // link memory, one write and one registered read
  logic             we;
  logic [BlkW-1:0]  wa, ra;
  logic [LinkW-1:0] wd;
  always_comb begin
    we = 1'b0;
    wa = blk_q;
    wd = heads_q[hidx];
    ra = blk_q;
    case (ctl_i.op)
      OpSplit: begin
        we = 1'b1;
        wa = blk_q + half;
        wd = heads_q[HeadIdxW'(p_q - 2'd2)];
      end
      OpPushLast: we = 1'b1;
      OpUnlink: begin
        we = !at_head_q;
        wa = prev_q;
        wd = rd_link;
      end
      OpPop:    ra = heads_q[hidx][BlkW-1:0];
      OpFindRd: ra = cur_q[BlkW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) links[wa] <= wd;
    rd_mem_q <= links[ra];
  end

  // entry 0 reads as null until it is first written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link0_set_q <= 1'b0;
      rd_zero_q   <= 1'b0;
    end else begin
      if (we && wa == '0) link0_set_q <= 1'b1;
      rd_zero_q <= (ra == '0) && !link0_set_q;
    end
  end

  assign rd_link = rd_zero_q ? '0 : rd_mem_q;

  // head registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < HeapOrder; i++) heads_q[i] <= '0;
      heads_q[HeapOrder-1] <= {1'b1, {BlkW{1'b0}}};
    end else begin
      case (ctl_i.op)
        OpPopDone: heads_q[hidx] <= rd_link;
        OpSplit:   heads_q[HeadIdxW'(p_q - 2'd2)] <=
                     {1'b1, blk_q + half};
        OpUnlink:  if (at_head_q) heads_q[hidx] <= rd_link;
        OpPushLast: heads_q[hidx] <= {1'b1, blk_q};
        default: ;
      endcase
    end
  end

  // operation registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
      free_q <= 1'b0;
      bad_q <= 1'b0;
    end else begin
      case (ctl_i.op)
        OpLoad: begin
          free_q  <= cmd_i;
          bad_q   <= ld_bad;
          want_q  <= ld_ord;
          p_q     <= ld_ord;
          blk_q   <= block_offset_i[OffW-1:MinOrder];
          ok_q    <= 1'b0;
        end
        OpScanUp: p_q <= p_q + 1'b1;
        OpPop: begin
          blk_q <= heads_q[hidx][BlkW-1:0];
          ok_q  <= 1'b1;
        end
        OpSplit: p_q <= p_q - 1'b1;
        OpFindStart: begin
          cur_q     <= heads_q[hidx];
          at_head_q <= 1'b1;
          steps_q   <= '0;
        end
        OpFindStep: begin
          prev_q    <= cur_q[BlkW-1:0];
          at_head_q <= 1'b0;
          cur_q     <= rd_link;
          steps_q   <= steps_q + 1'b1;
        end
        OpUnlink: begin
          blk_q <= blk_q & ~span;
          p_q   <= p_q + 1'b1;
        end
        OpPushLast: ok_q <= 1'b1;
        default: ;
      endcase
    end
  end

  assign sts_o.req_bad    = bad_q;
  assign sts_o.is_free    = free_q;
  assign sts_o.head_valid = heads_q[hidx][BlkW];
  assign sts_o.p_top      = (p_q >= OrdW'(HeapOrder));
  assign sts_o.p_want     = (p_q == want_q);
  assign sts_o.cur_valid  = cur_q[BlkW];
  assign sts_o.cur_hit    = (cur_q[BlkW-1:0] == buddy);
  assign sts_o.steps_done = steps_q[BlkW];

  assign res_ok_o  = ok_q;
  assign res_off_o = (ok_q && !free_q) ? {blk_q, {MinOrder{1'b0}}} : '0;
endmodule

>>> design/buddy_allocator_free_lists.sv
// buddy_allocator_free_lists: stream top level of the buddy allocator
// depends on bafl_pkg, bafl_ctrl, bafl_dp
// sequence: allocate loads, scans up the orders, pops the head block and splits down to
//   the wanted order; free loads, searches each order list for the buddy, unlinks and
//   merges it, then pushes the merged block; both then reply
// throughput: one item at a time; ready again the cycle after the result is registered
// reset: heap is one free block at offset 0, all other lists empty
module buddy_allocator_free_lists (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // cmd, req_size[16:0], block_offset[15:0], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // ok, alloc_offset[15:0], zero pad
);
  import bafl_pkg::*;

  ctl_t ctl;
  sts_t sts;
  logic idle, res_ok;
  logic [OffW-1:0] res_off;
  logic out_v_q;
  logic [OffW:0] out_q;

  assign s_axis_tready = idle;

  bafl_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(s_axis_tvalid && idle),
    .sts_i(sts),
    .out_free_i(!out_v_q || m_axis_tready),
    .ctl_o(ctl),
    .idle_o(idle)
  );

  bafl_dp u_dp (
    .clk_i, .rst_ni,
    .ctl_i(ctl),
    .cmd_i(s_axis_tdata[0]),
    .req_size_i(s_axis_tdata[17:1]),
    .block_offset_i(s_axis_tdata[33:18]),
    .sts_o(sts),
    .res_ok_o(res_ok),
    .res_off_o(res_off)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      out_q   <= '0;
    end else if (ctl.op == OpReply) begin
      out_v_q <= 1'b1;
      out_q   <= {res_off, res_ok};
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {7'b0, out_q};
endmodule

>>> design/bafl_checker.sv
// bafl_checker: port level assertions for the buddy allocator
// depends on buddy_allocator_free_lists ports
module bafl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under stall");
  // failed result carries zero offset
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[16:1] == 16'd0)
    else $error("nonzero offset on failure");
  // accepted item is not accepted again next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready right after accept");
  // allocated offsets are word aligned
  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[2:1] == 2'b00)
    else $error("misaligned offset");
endmodule

bind buddy_allocator_free_lists bafl_checker u_chk (.*);

>>> dv/tb_top.sv
// tb_top: stream testbench for buddy_allocator_free_lists
// depends on bafl_pkg and the allocator rtl; holds its own heap model
`timescale 1ns / 1ps

module tb_top;
  import bafl_pkg::*;

  localparam int NumBlk   = 1 << BlkW;
  localparam int HeapSize = 1 << HeapOrder;
  localparam int LimitCyc = 4000000;

  typedef struct packed {
    logic            cmd;
    logic [SizeW-1:0] size;
    logic [OffW-1:0]  off;
  } req_t;

  typedef struct packed {
    logic            ok;
    logic [OffW-1:0] off;
  } rsp_t;

  typedef struct {
    int off;
    int ord;
  } live_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // cmd, req_size[16:0], block_offset[15:0], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // ok, alloc_offset[15:0], zero pad

  buddy_allocator_free_lists dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // heap model: list heads per order and next links per block
  logic [LinkW-1:0] free_head[HeapOrder];
  logic [LinkW-1:0] next_link[NumBlk];

  req_t  req_q[$];
  rsp_t  rsp_q[$];
  live_t live_q[$];
  int    err_cnt;
  int    cyc_cnt;

  function automatic int size_order(int n);
    int p;
    int m;
    p = 0;
    m = n - 1;
    while (m != 0) begin
      p++;
      m = m >> 1;
    end
    return (p < MinOrder) ? MinOrder : p;
  endfunction

  function automatic void push_free(int p, int blk);
    next_link[blk] = free_head[p-1];
    free_head[p-1] = {1'b1, BlkW'(blk)};
  endfunction

  // unlink blk from the order-p list, bounded walk
  function automatic bit unlink_free(int p, int blk);
    logic [LinkW-1:0] cur;
    int prev;
    bit at_head;
    cur = free_head[p-1];
    prev = 0;
    at_head = 1;
    for (int s = 0; s < NumBlk; s++) begin
      if (!cur[BlkW]) return 0;
      if (int'(cur[BlkW-1:0]) == blk) begin
        if (at_head) free_head[p-1] = next_link[blk];
        else next_link[prev] = next_link[blk];
        return 1;
      end
      prev = int'(cur[BlkW-1:0]);
      at_head = 0;
      cur = next_link[prev];
    end
    return 0;
  endfunction

  function automatic rsp_t heap_step(req_t r);
    rsp_t res;
    int want, p, blk, span;
    res = '0;
    if (r.size == 0) return res;
    want = size_order(int'(r.size));
    if (want > HeapOrder) return res;
    if (r.cmd == CmdAlloc) begin
      p = want;
      while (!free_head[p-1][BlkW]) begin
        p++;
        if (p > HeapOrder) return res;
      end
      blk = int'(free_head[p-1][BlkW-1:0]);
      free_head[p-1] = next_link[blk];
      while (p > want) begin
        push_free(p - 1, blk + (1 << (p - 1 - MinOrder)));
        p--;
      end
      res.ok = 1'b1;
      res.off = OffW'(blk << MinOrder);
    end else begin
      if ((int'(r.off) & ((1 << want) - 1)) != 0) return res;
      blk = int'(r.off) >> MinOrder;
      p = want;
      while (p < HeapOrder) begin
        span = 1 << (p - MinOrder);
        if (!unlink_free(p, blk ^ span)) break;
        blk = blk & ~span;
        p++;
      end
      push_free(p, blk);
      res.ok = 1'b1;
    end
    return res;
  endfunction

  // queue one item and its predicted result; track live blocks
  task automatic add_item(logic cmd, int size, int off);
    req_t r;
    rsp_t e;
    r.cmd = cmd;
    r.size = SizeW'(size);
    r.off = OffW'(off);
    e = heap_step(r);
    req_q.push_back(r);
    rsp_q.push_back(e);
    if (cmd == CmdAlloc && e.ok) live_q.push_back('{int'(e.off), size_order(size)});
  endtask

  // free a random live block with a random size of the same order
  task automatic free_live();
    int i, p, sz;
    live_t b;
    i = $urandom_range(0, live_q.size() - 1);
    b = live_q[i];
    live_q.delete(i);
    p = b.ord;
    sz = (p == MinOrder) ? $urandom_range(1, 4) : $urandom_range((1 << (p-1)) + 1, 1 << p);
    add_item(CmdFree, sz, b.off);
  endtask

  function automatic int rand_size();
    int k;
    k = $urandom_range(0, 99);
    if (k < 65) return $urandom_range(1, 64);
    if (k < 90) return $urandom_range(65, 4096);
    return $urandom_range(4097, HeapSize);
  endfunction

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sender: bursts and gaps, changes at the falling edge
  logic in_fire;
  int   burst_left, gap_left;
  always @(posedge clk_i) in_fire <= s_axis_tvalid && s_axis_tready;

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_axis_tvalid <= 1'b0;
      end else if (req_q.size() > 0) begin
        req_t r;
        r = req_q.pop_front();
        s_axis_tdata <= {6'b0, r.off, r.size, r.cmd};
        s_axis_tvalid <= 1'b1;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern that switches between random modes
  int rdy_mode;
  always @(negedge clk_i) begin
    if (cyc_cnt % 64 == 0) rdy_mode <= $urandom_range(0, 3);
    case (rdy_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= (cyc_cnt % 5 != 0);
    endcase
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rsp_t e;
      if (rsp_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result item: ok=%0b off=%0h",
                                    m_axis_tdata[0], m_axis_tdata[16:1]);
      end else begin
        e = rsp_q.pop_front();
        if (m_axis_tdata[0] !== e.ok || m_axis_tdata[16:1] !== e.off) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result mismatch: exp ok=%0b off=%0h, got ok=%0b off=%0h",
                     e.ok, e.off, m_axis_tdata[0], m_axis_tdata[16:1]);
        end
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt > LimitCyc) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    int k, x;
    err_cnt = 0;
    cyc_cnt = 0;
    in_fire = 1'b0;
    burst_left = 0;
    gap_left = 0;
    rdy_mode = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    for (int i = 0; i < HeapOrder; i++) free_head[i] = '0;
    free_head[HeapOrder-1] = {1'b1, BlkW'(0)};
    next_link[0] = '0;

    // directed: whole heap, exhaustion, size edge cases, ignored frees
    add_item(CmdAlloc, HeapSize, 0);
    add_item(CmdAlloc, 4, 0);
    add_item(CmdFree, HeapSize, 0);
    add_item(CmdAlloc, 0, 16'hffff);
    add_item(CmdAlloc, HeapSize + 1, 0);
    add_item(CmdAlloc, 131071, 0);
    add_item(CmdFree, 0, 0);
    add_item(CmdFree, 131071, 0);
    add_item(CmdFree, 4, 16'hffff);
    add_item(CmdFree, 8, 16'h5554);
    add_item(CmdFree, HeapSize, 16'h8000);
    add_item(CmdAlloc, 1, 0);
    add_item(CmdAlloc, 3, 0);
    add_item(CmdAlloc, 5, 0);
    add_item(CmdAlloc, 32768, 0);
    add_item(CmdAlloc, 32768, 0);
    add_item(CmdAlloc, 16385, 0);
    while (live_q.size() > 0) free_live();

    // random: mostly well-formed alloc/free traffic, some rejected items
    for (int n = 0; n < 400; n++) begin
      k = $urandom_range(0, 99);
      if (k < 4) add_item(1'($urandom_range(0, 1)), 0, $urandom_range(0, 65535));
      else if (k < 8) add_item(1'($urandom_range(0, 1)), $urandom_range(HeapSize + 1, 131071),
                               $urandom_range(0, 65535));
      else if (k < 13) add_item(CmdFree, rand_size(), $urandom_range(0, 65535) | 1);
      else if (live_q.size() > 0 && (k < 55 || live_q.size() > 40)) free_live();
      else add_item(CmdAlloc, rand_size(), $urandom_range(0, 65535));
    end
    while (live_q.size() > 0) free_live();

    // double free at the very end corrupts a list
    add_item(CmdAlloc, 4, 0);
    x = live_q[0].off;
    add_item(CmdFree, 4, x);
    add_item(CmdFree, 4, x);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (req_q.size() == 0 && rsp_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0 && rsp_q.size() == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

endmodule
